// ----- rtl/bcpe_pkg.sv -----
// Shared constants for the Bezier curve point evaluator.
// Register indices, field widths, degree limits and pipeline depth.
// No dependencies.
package bcpe_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int NUM_POINTS = 5;
    localparam int NUM_ROUNDS = NUM_POINTS - 1;
    localparam int NUM_AXES   = 2;
    localparam int AXIS_X     = 0;
    localparam int AXIS_Y     = 1;

    localparam int HALF_W     = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_DATA_W = 2 * HALF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int DEG_W      = 3;

    localparam logic [DEG_W-1:0] DEG_MIN   = DEG_W'(2);
    localparam logic [DEG_W-1:0] DEG_MAX   = DEG_W'(4);
    localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(3);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_1 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_2 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_3 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_4 = CFG_IDX_W'(5);

    // input register plus two stages per round
    localparam int LATENCY = 1 + 2 * NUM_ROUNDS;

endpackage

// ----- rtl/bcpe_round.sv -----
// One de Casteljau round for both axes, two register stages.
// Stage A: difference and split multiply by t. Stage B: shift and sum.
// Depends on bcpe_pkg.
module bcpe_round
    import bcpe_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    parameter int ROUND       = 1,
    localparam int BW_IN      = COORD_BITS + (ROUND - 1) * T_FRAC_BITS,
    localparam int BW_OUT     = BW_IN + T_FRAC_BITS,
    localparam int NIN        = NUM_POINTS - ROUND + 1,
    localparam int NOUT       = NUM_POINTS - ROUND,
    localparam int TW         = T_FRAC_BITS + 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [TW-1:0]            t_in,
    input  logic [DEG_W-1:0]         deg,
    input  logic signed [BW_IN-1:0]  b_in  [NUM_AXES][NIN],
    output logic                     out_valid,
    output logic [TW-1:0]            t_out,
    output logic signed [BW_OUT-1:0] b_out [NUM_AXES][NOUT]
);

    localparam int DW   = BW_IN + 1;
    localparam int LO_W = DW / 2;
    localparam int HI_W = DW - LO_W;
    localparam int PL_W = LO_W + TW;
    localparam int PH_W = HI_W + TW + 1;

    logic signed [DW-1:0]     diff      [NUM_AXES][NOUT];
    logic [PL_W-1:0]          pl_next   [NUM_AXES][NOUT];
    logic signed [PH_W-1:0]   ph_next   [NUM_AXES][NOUT];
    logic signed [BW_OUT-1:0] sum_next  [NUM_AXES][NOUT];

    logic                     va_reg;
    logic [TW-1:0]            ta_reg;
    logic signed [BW_IN-1:0]  base_reg  [NUM_AXES][NOUT];
    logic [PL_W-1:0]          pl_reg    [NUM_AXES][NOUT];
    logic signed [PH_W-1:0]   ph_reg    [NUM_AXES][NOUT];

    logic                     vb_reg;
    logic [TW-1:0]            tb_reg;
    logic signed [BW_OUT-1:0] sum_reg   [NUM_AXES][NOUT];

    // b*u + b1*t == b*one + (b1 - b)*t; points beyond the degree get a zero
    // difference so the lower-degree result is only scaled by one
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int i = 0; i < NOUT; i++)
            begin
                if ((i + ROUND) <= int'(deg))
                begin
                    diff[a][i] = DW'(b_in[a][i + 1]) - DW'(b_in[a][i]);
                end
                else
                begin
                    diff[a][i] = '0;
                end
                pl_next[a][i] = diff[a][i][LO_W-1:0] * t_in;
                ph_next[a][i] = $signed(diff[a][i][DW-1:LO_W]) * $signed({1'b0, t_in});
            end
        end
    end

    // exact result fits BW_OUT, so modular sums at that width are exact
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int i = 0; i < NOUT; i++)
            begin
                sum_next[a][i] = (BW_OUT'(base_reg[a][i]) <<< T_FRAC_BITS)
                               + (BW_OUT'(ph_reg[a][i]) <<< LO_W)
                               + BW_OUT'(pl_reg[a][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg <= t_in;
        tb_reg <= ta_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int i = 0; i < NOUT; i++)
            begin
                base_reg[a][i] <= b_in[a][i];
                pl_reg[a][i]   <= pl_next[a][i];
                ph_reg[a][i]   <= ph_next[a][i];
                sum_reg[a][i]  <= sum_next[a][i];
            end
        end
    end

    assign out_valid = vb_reg;
    assign t_out     = tb_reg;
    assign b_out     = sum_reg;

endmodule

// ----- rtl/bezier_curve_point_eval.sv -----
// Top level of the Bezier curve point evaluator (degree 2 to 4, 2D).
// Holds the configuration registers and chains four bcpe_round stages.
// Depends on bcpe_pkg and bcpe_round.
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+-------------------------------
//  request   | start, busy, t_param               | taken when start && !busy
//  result    | done, curve_x, curve_y             | one-cycle strobe, no back-pressure
//  config    | wr_en, wr_index, wr_data           | write on wr_en, no wait
//
//  From request to done a request passes one input register, then two
//  register stages for each of the four de Casteljau rounds.
//  One request per cycle is taken; busy stays low, nothing ever stalls.
//  Lower degrees run through all four rounds with zero differences, which
//  only scales the point by one, so latency does not depend on degree.
//  rst_n (asynchronous, active low) clears the valid pipeline and loads
//  degree 3 and all control points to zero.
module bezier_curve_point_eval
    import bcpe_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [T_FRAC_BITS:0]    t_param,
    output logic                    done,
    output logic signed [OUT_W-1:0] curve_x,
    output logic signed [OUT_W-1:0] curve_y,
    input  logic                    wr_en,
    input  logic [CFG_IDX_W-1:0]    wr_index,
    input  logic [CFG_DATA_W-1:0]   wr_data
);

    localparam int TW = T_FRAC_BITS + 1;
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    localparam int BW0 = COORD_BITS;
    localparam int BW1 = BW0 + T_FRAC_BITS;
    localparam int BW2 = BW1 + T_FRAC_BITS;
    localparam int BW3 = BW2 + T_FRAC_BITS;
    localparam int BW4 = BW3 + T_FRAC_BITS;

    // configuration registers
    logic [DEG_W-1:0]      degree_reg;
    logic [CFG_DATA_W-1:0] point_reg [NUM_POINTS];
    logic [DEG_W-1:0]      deg_eff;

    // input stage
    logic                  v0_reg;
    logic [TW-1:0]         t0_reg;
    logic [TW-1:0]         t_sat;

    // round chain
    logic signed [BW0-1:0] b0 [NUM_AXES][NUM_POINTS];
    logic signed [BW1-1:0] b1 [NUM_AXES][NUM_POINTS - 1];
    logic signed [BW2-1:0] b2 [NUM_AXES][NUM_POINTS - 2];
    logic signed [BW3-1:0] b3 [NUM_AXES][NUM_POINTS - 3];
    logic signed [BW4-1:0] b4 [NUM_AXES][NUM_POINTS - 4];
    logic                  v1, v2, v3, v4;
    logic [TW-1:0]         t1, t2, t3;

    logic signed [COORD_BITS-1:0] res_x;
    logic signed [COORD_BITS-1:0] res_y;

    // ---- configuration port ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEG_RESET;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DEGREE:  degree_reg   <= wr_data[DEG_W-1:0];
                REG_POINT_0: point_reg[0] <= wr_data;
                REG_POINT_1: point_reg[1] <= wr_data;
                REG_POINT_2: point_reg[2] <= wr_data;
                REG_POINT_3: point_reg[3] <= wr_data;
                REG_POINT_4: point_reg[4] <= wr_data;
                default:     ;  // unmapped index, write dropped
            endcase
        end
    end

    // degree outside 2..4 is clamped
    always_comb
    begin
        if (degree_reg < DEG_MIN)
        begin
            deg_eff = DEG_MIN;
        end
        else if (degree_reg > DEG_MAX)
        begin
            deg_eff = DEG_MAX;
        end
        else
        begin
            deg_eff = degree_reg;
        end
    end

    // coordinates: low COORD_BITS of each half, two's complement
    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            b0[AXIS_X][i] = point_reg[i][COORD_BITS-1:0];
            b0[AXIS_Y][i] = point_reg[i][HALF_W +: COORD_BITS];
        end
    end

    // ---- input stage: t above one saturates, no extrapolation ----
    assign busy  = 1'b0;
    assign t_sat = (t_param > T_ONE) ? T_ONE : t_param;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg <= t_sat;
    end

    // ---- four rounds of de Casteljau ----
    bcpe_round #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .ROUND       (1)
    ) u_round1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .t_in      (t0_reg),
        .deg       (deg_eff),
        .b_in      (b0),
        .out_valid (v1),
        .t_out     (t1),
        .b_out     (b1)
    );

    bcpe_round #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .ROUND       (2)
    ) u_round2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .t_in      (t1),
        .deg       (deg_eff),
        .b_in      (b1),
        .out_valid (v2),
        .t_out     (t2),
        .b_out     (b2)
    );

    bcpe_round #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .ROUND       (3)
    ) u_round3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .t_in      (t2),
        .deg       (deg_eff),
        .b_in      (b2),
        .out_valid (v3),
        .t_out     (t3),
        .b_out     (b3)
    );

    bcpe_round #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .ROUND       (4)
    ) u_round4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .t_in      (t3),
        .deg       (deg_eff),
        .b_in      (b3),
        .out_valid (v4),
        .t_out     (),
        .b_out     (b4)
    );

    // ---- result: b0 is scaled by one^4; floor shift back to Q16.16 ----
    assign res_x   = b4[AXIS_X][0][NUM_ROUNDS * T_FRAC_BITS +: COORD_BITS];
    assign res_y   = b4[AXIS_Y][0][NUM_ROUNDS * T_FRAC_BITS +: COORD_BITS];
    assign curve_x = OUT_W'(res_x);
    assign curve_y = OUT_W'(res_y);
    assign done    = v4;

endmodule

// ----- rtl/bcpe_checker.sv -----
// Port-level checks for bezier_curve_point_eval, bound to the top level.
// Checks request-to-result timing, the never-busy promise and known values.
// Depends on bcpe_pkg.
module bcpe_checker
    import bcpe_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [T_FRAC_BITS:0]    t_param,
    input logic                    done,
    input logic signed [OUT_W-1:0] curve_x,
    input logic signed [OUT_W-1:0] curve_y
);

    // every request gives its result after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request without result after pipeline latency");

    // no result without a matching request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe with no request");

    // fully pipelined: requests are never refused
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // a taken request carries a known parameter
    a_request_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(t_param))
        else $error("request with unknown t_param");

    // a result strobe carries a known point
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({curve_x, curve_y}))
        else $error("result with unknown coordinates");

endmodule

bind bezier_curve_point_eval bcpe_checker #(
    .T_FRAC_BITS (T_FRAC_BITS)
) u_bcpe_checker (.*);

// ----- sim/bcpe_point_scoreboard.sv -----
`timescale 1ns / 100ps
// Scoreboard for bezier_curve_point_eval: mirrors the register writes, predicts
// the curve point of each accepted request and checks it against the done strobe.
// Depends on bcpe_pkg.
module bcpe_point_scoreboard
    import bcpe_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [T_FRAC_BITS:0]    t_param,
    input  logic                    done,
    input  logic signed [OUT_W-1:0] curve_x,
    input  logic signed [OUT_W-1:0] curve_y,
    input  logic                    wr_en,
    input  logic [CFG_IDX_W-1:0]    wr_index,
    input  logic [CFG_DATA_W-1:0]   wr_data,
    output int                      fail_count,
    output int                      pending,
    output int                      points_checked
);

    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    typedef struct {
        logic [T_FRAC_BITS:0] t;
        logic [DEG_W-1:0]     deg;
        logic [OUT_W-1:0]     x;
        logic [OUT_W-1:0]     y;
    } curve_point_t;

    curve_point_t         expected_points[$];
    logic [DEG_W-1:0]     degree_reg;
    logic [CFG_DATA_W-1:0] ctrl_pts [NUM_POINTS];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        fail_count++;
    endtask

    // degree register clamped to the supported range
    function automatic int clamp_degree(input logic [DEG_W-1:0] d);
        if (d < DEG_MIN)
            return int'(DEG_MIN);
        if (d > DEG_MAX)
            return int'(DEG_MAX);
        return int'(d);
    endfunction

    // exact de Casteljau on one axis, then floor to Q16.16
    function automatic logic [OUT_W-1:0] blend_axis(input int n, input int axis,
                                                    input logic [T_FRAC_BITS:0] t);
        logic signed [127:0]          b [NUM_POINTS];
        logic signed [127:0]          tw;
        logic signed [127:0]          uw;
        logic signed [127:0]          s;
        logic signed [COORD_BITS-1:0] c;
        tw = 128'(t);
        uw = 128'(T_ONE) - tw;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            c    = ctrl_pts[i][axis*HALF_W +: COORD_BITS];
            b[i] = c;
        end
        for (int r = 1; r <= n; r++)
            for (int i = 0; i + r <= n; i++)
                b[i] = b[i] * uw + b[i+1] * tw;
        s = b[0] >>> (n * T_FRAC_BITS);
        return s[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        curve_point_t         e;
        logic [T_FRAC_BITS:0] t_sat;
        int                   n;
        if (!rst_n)
        begin
            degree_reg = DEG_RESET;
            for (int i = 0; i < NUM_POINTS; i++)
                ctrl_pts[i] = '0;
            expected_points.delete();
        end
        else
        begin
            // results first: a point leaving never belongs to a request arriving
            if (done)
            begin
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("point with no request: x=%h y=%h",
                                              curve_x, curve_y));
                else
                begin
                    e = expected_points.pop_front();
                    points_checked++;
                    if (curve_x !== e.x)
                        report_mismatch($sformatf("curve_x t=%h deg=%0d got %h want %h",
                                                  e.t, e.deg, curve_x, e.x));
                    if (curve_y !== e.y)
                        report_mismatch($sformatf("curve_y t=%h deg=%0d got %h want %h",
                                                  e.t, e.deg, curve_y, e.y));
                end
            end
            if (start && !busy)
            begin
                t_sat = (t_param > T_ONE) ? T_ONE : t_param;
                n     = clamp_degree(degree_reg);
                e.t   = t_param;
                e.deg = degree_reg;
                e.x   = blend_axis(n, AXIS_X, t_sat);
                e.y   = blend_axis(n, AXIS_Y, t_sat);
                expected_points.push_back(e);
            end
            if (wr_en)
            begin
                case (wr_index) inside
                    REG_DEGREE:
                        degree_reg = wr_data[DEG_W-1:0];
                    REG_POINT_0, REG_POINT_1, REG_POINT_2, REG_POINT_3, REG_POINT_4:
                        ctrl_pts[wr_index - REG_POINT_0] = wr_data;
                    default:
                        ; // unmapped index, write dropped
                endcase
            end
        end
        pending = expected_points.size();
    end

endmodule

// ----- sim/tb_bezier_curve_point_eval.sv -----
`timescale 1ns / 100ps
// Testbench top for bezier_curve_point_eval: drives requests and register writes,
// gives the verdict. Depends on bcpe_pkg, bezier_curve_point_eval, bcpe_point_scoreboard.
module tb_bezier_curve_point_eval;
    import bcpe_pkg::*;

    // Run shape: a directed opener, then random register settings each followed by
    // a burst of requests. Sender idling is 21 %, then 63 %, then none at all.
    localparam int TOTAL_RANDOM  = 1550;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int T_ONE         = 1 << T_FRAC_BITS_DEF;
    localparam int TW            = T_FRAC_BITS_DEF + 1;

    localparam logic [HALF_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [HALF_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [HALF_W-1:0] COORD_ONE = 32'h0001_0000;

    // indices beyond the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7 = CFG_IDX_W'(7);

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [TW-1:0]           t_param;
    logic                    done;
    logic signed [OUT_W-1:0] curve_x;
    logic signed [OUT_W-1:0] curve_y;
    logic                    wr_en;
    logic [CFG_IDX_W-1:0]    wr_index;
    logic [CFG_DATA_W-1:0]   wr_data;

    int fail_count;
    int pending;
    int points_checked;
    int cycle_count;
    int requests_sent;
    int settings_used;
    int saturated_sent;

    bezier_curve_point_eval dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .t_param  (t_param),
        .done     (done),
        .curve_x  (curve_x),
        .curve_y  (curve_y),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    bcpe_point_scoreboard scoreboard
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .t_param        (t_param),
        .done           (done),
        .curve_x        (curve_x),
        .curve_y        (curve_y),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .points_checked (points_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bezier_curve_point_eval test failed");
            $finish;
        end
    end

    // Inputs move on the falling edge; the block samples them on the rising one.
    // start is left high between back-to-back requests, only t_param changes.
    task automatic issue_request(input logic [TW-1:0] t);
        @(negedge clk);
        start   = 1'b1;
        t_param = t;
        requests_sent++;
        if (t > TW'(T_ONE))
            saturated_sent++;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Hold off until every predicted point has come back.
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = d;
        @(negedge clk);
        wr_en    = 1'b0;
    endtask

    task automatic write_point(input int i, input logic [HALF_W-1:0] x,
                               input logic [HALF_W-1:0] y);
        cfg_write(REG_POINT_0 + CFG_IDX_W'(i), {y, x});
    endtask

    // degree write with junk in the unused upper bits
    task automatic write_degree(input logic [DEG_W-1:0] d);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom(), $urandom()};
        cfg_write(REG_DEGREE, {junk[CFG_DATA_W-1:DEG_W], d});
    endtask

    // t: biased towards 0, exactly one and the saturating range
    function automatic logic [TW-1:0] rand_t();
        case ($urandom_range(11)) inside
            0:       return '0;
            1:       return TW'(T_ONE);
            2:       return '1;
            [3:4]:   return TW'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
            default: return TW'($urandom_range(0, T_ONE));
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return HALF_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return $urandom();
        endcase
    endfunction

    // New register setting; occasionally leaves a point as it was, and now and
    // then pokes an unmapped index.
    task automatic load_random_setting();
        logic [DEG_W-1:0] deg;
        case ($urandom_range(9))
            0:       deg = DEG_MIN;
            1:       deg = DEG_MAX;
            2:       deg = DEG_W'($urandom_range(7));
            default: deg = DEG_W'($urandom_range(DEG_MIN, DEG_MAX));
        endcase
        write_degree(deg);
        for (int i = 0; i < NUM_POINTS; i++)
            if ($urandom_range(5) != 0)
                write_point(i, rand_coord(), rand_coord());
        if ($urandom_range(7) == 0)
            cfg_write($urandom_range(1) ? REG_UNMAPPED_6 : REG_UNMAPPED_7,
                      {$urandom(), $urandom()});
        settings_used++;
    endtask

    initial
    begin
        int burst;
        int idle_pct;
        int issued;

        start    = 1'b0;
        t_param  = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed opener ---
        // reset setting: cubic, all points at the origin
        issue_request('0);
        issue_request(TW'(T_ONE));
        drain_results();

        // quartic on extreme coordinates, t across zero, one and saturation
        write_degree(DEG_MAX);
        write_point(0, COORD_MAX, COORD_MIN);
        write_point(1, COORD_MIN, COORD_MAX);
        write_point(2, COORD_MAX, COORD_MAX);
        write_point(3, COORD_MIN, COORD_MIN);
        write_point(4, COORD_ONE, ~COORD_ONE + 1'b1);
        issue_request('0);
        issue_request(TW'(1));
        issue_request(TW'(T_ONE / 2));
        issue_request(TW'(T_ONE - 1));
        issue_request(TW'(T_ONE));
        issue_request(TW'(T_ONE + 1));
        issue_request('1);
        drain_results();

        // quadratic
        write_degree(DEG_MIN);
        issue_request('0);
        issue_request(TW'(T_ONE / 4));
        issue_request(TW'(T_ONE));
        issue_request(TW'(T_ONE + T_ONE / 2));
        drain_results();

        // cubic: point 3 now matters
        write_degree(DEG_RESET);
        issue_request('0);
        issue_request(TW'(3 * T_ONE / 4));
        issue_request('1);
        drain_results();

        // degree below two behaves as quadratic
        write_degree(DEG_W'(0));
        issue_request(TW'(T_ONE / 2));
        issue_request(TW'(17'h1234));
        drain_results();

        // degree above four behaves as quartic
        write_degree(DEG_W'(7));
        issue_request(TW'(T_ONE / 2));
        issue_request(TW'(17'h0ABCD));
        drain_results();

        // quadratic again with points 3 and 4 moved: must not change the result
        write_degree(DEG_MIN);
        write_point(3, 32'h1234_5678, 32'hFEDC_BA98);
        write_point(4, COORD_MIN, COORD_MAX);
        issue_request(TW'(T_ONE / 4));
        issue_request(TW'(T_ONE / 2));
        drain_results();

        // writes to unmapped indices are dropped
        cfg_write(REG_UNMAPPED_6, '1);
        cfg_write(REG_UNMAPPED_7, '1);
        issue_request(TW'(T_ONE / 3));
        drain_results();

        // --- random bursts ---
        issued = 0;
        while (issued < TOTAL_RANDOM)
        begin
            load_random_setting();
            if (issued < TOTAL_RANDOM / 3)
                idle_pct = 21;
            else if (issued < 2 * TOTAL_RANDOM / 3)
                idle_pct = 63;
            else
                idle_pct = 0;
            burst = $urandom_range(30, 110);
            for (int k = 0; k < burst && issued < TOTAL_RANDOM; k++)
            begin
                // each sender cycle is left empty with chance idle_pct in a hundred
                while ($urandom_range(99) < idle_pct)
                    idle_cycles(1);
                issue_request(rand_t());
                issued++;
                // now and then let the pipe run empty mid-burst
                if ($urandom_range(63) == 0)
                    drain_results();
            end
            drain_results();
        end

        // flush, then allow for any stray strobe
        drain_results();
        repeat (LATENCY + 4) @(posedge clk);

        $display("Sent %0d requests (%0d with t above one), %0d random settings and directed",
                 requests_sent, saturated_sent, settings_used);
        $display("Compared %0d curve points, %0d left outstanding, %0d mismatches",
                 points_checked, pending, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("bezier_curve_point_eval test passed");
        else
            $display("bezier_curve_point_eval test failed");
        $finish;
    end

endmodule
